[hw/rtl/azgap_pkg.sv]
package azgap_pkg;

  // default store depth, in arrivals
  localparam int MAX_ARRIVALS_DEF = 64;

  // angles in hundredths of a degree
  localparam logic [15:0] FULL_CIRCLE = 16'd36000;
  localparam logic [14:0] HALF_CIRCLE = 15'd18000;

  // one arrival word
  typedef struct packed {
    logic [14:0] distance;
    logic [15:0] azimuth;
    logic        excluded;
    logic        last;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [14:0] min_distance;
    logic [14:0] max_distance;
    logic [15:0] largest_gap;
    logic        empty_set;
    logic        overflow;
  } out_word_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the accepted word, update min, max and overflow
    logic ins_read;    // read the entry below the insertion point
    logic ins_shift;   // move the read entry up one place
    logic ins_place;   // write the new azimuth at the insertion point
    logic scan_init;   // start the gap scan at entry zero
    logic scan_read;   // read the scan entry
    logic scan_acc;    // fold the read entry into the gap
    logic scan_wrap;   // fold in the wrap gap
    logic clear;       // start a new set
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic excluded;    // held word is excluded
    logic last;        // held word ends the set
    logic full;        // store holds the maximum number of azimuths
    logic pos_zero;    // insertion point at the bottom of the store
    logic rd_greater;  // read entry is above the new azimuth
    logic count_zero;  // no azimuth stored
    logic scan_last;   // scan entry is the top stored one
  } dp_status_t;

endpackage

[hw/rtl/azgap_dp.sv]
module azgap_dp #(
  parameter int MAX_ARRIVALS = azgap_pkg::MAX_ARRIVALS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  azgap_pkg::in_word_t   in_data,
  input  azgap_pkg::dp_cmd_t    cmd,
  output azgap_pkg::dp_status_t status,
  output azgap_pkg::out_word_t  out_data
);
  import azgap_pkg::*;

  localparam int AW = $clog2(MAX_ARRIVALS);
  localparam int CW = $clog2(MAX_ARRIVALS + 1);

  logic [15:0]   mem [MAX_ARRIVALS];
  logic [15:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_minus_one;
  logic [AW-1:0] idx;
  logic [15:0]   az;
  logic          excluded;
  logic          last;
  logic [14:0]   run_min;
  logic [14:0]   run_max;
  logic          ovf;
  logic [15:0]   first_az;
  logic [15:0]   prev_az;
  logic [15:0]   best;

  logic [14:0]   dist_sat;
  logic [15:0]   az_wrapped;
  logic [15:0]   diff;
  logic [16:0]   wrap_gap;
  logic          empty;

  // input conditioning
  assign dist_sat   = (in_data.distance > HALF_CIRCLE) ? HALF_CIRCLE : in_data.distance;
  assign az_wrapped = (in_data.azimuth >= FULL_CIRCLE) ? in_data.azimuth - FULL_CIRCLE
                                                       : in_data.azimuth;

  // gap arithmetic
  assign diff     = rd_data - prev_az;
  assign wrap_gap = {1'b0, first_az} + {1'b0, FULL_CIRCLE} - {1'b0, prev_az};

  // store port selection
  assign pos_minus_one = pos - CW'(1);
  assign rd_en   = cmd.ins_read | cmd.scan_read;
  assign rd_addr = cmd.ins_read ? pos_minus_one[AW-1:0] : idx;
  assign wr_en   = cmd.ins_shift | cmd.ins_place;
  assign wr_addr = pos[AW-1:0];
  assign wr_data = cmd.ins_shift ? rd_data : az;

  // azimuth store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // set control registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count   <= '0;
      run_min <= HALF_CIRCLE;
      run_max <= '0;
      ovf     <= 1'b0;
    end else begin
      if (cmd.load && !in_data.excluded) begin
        if (dist_sat < run_min) begin
          run_min <= dist_sat;
        end
        if (dist_sat > run_max) begin
          run_max <= dist_sat;
        end
        if (count == CW'(MAX_ARRIVALS)) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.ins_place) begin
        count <= count + CW'(1);
      end
    end
  end

  // held word, insertion point and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      az       <= az_wrapped;
      excluded <= in_data.excluded;
      last     <= in_data.last;
      pos      <= count;
    end
    if (cmd.ins_shift) begin
      pos <= pos_minus_one;
    end
    if (cmd.scan_init) begin
      idx  <= '0;
      best <= '0;
    end
    if (cmd.scan_acc) begin
      idx     <= idx + AW'(1);
      prev_az <= rd_data;
      if (idx == '0) begin
        first_az <= rd_data;
      end else if (diff > best) begin
        best <= diff;
      end
    end
    if (cmd.scan_wrap && (wrap_gap > {1'b0, best})) begin
      best <= wrap_gap[15:0];
    end
  end

  // status
  assign status.excluded   = excluded;
  assign status.last       = last;
  assign status.full       = (count == CW'(MAX_ARRIVALS));
  assign status.pos_zero   = (pos == '0);
  assign status.rd_greater = (rd_data > az);
  assign status.count_zero = (count == '0);
  assign status.scan_last  = (CW'(idx) == count - CW'(1));

  // result word
  assign empty                 = (count == '0);
  assign out_data.min_distance = empty ? '0 : run_min;
  assign out_data.max_distance = empty ? '0 : run_max;
  assign out_data.largest_gap  = empty ? FULL_CIRCLE : best;
  assign out_data.empty_set    = empty;
  assign out_data.overflow     = empty ? 1'b0 : ovf;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ARRIVALS))
    else $error("stored azimuth count above store depth");

  a_place_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_place |=> count == $past(count) + CW'(1))
    else $error("placing an azimuth did not advance the count");

  a_shift_above_bottom: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_shift |-> !status.pos_zero && status.rd_greater)
    else $error("shift issued at the bottom or for a smaller entry");

  a_place_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_place |-> !status.full)
    else $error("azimuth placed into a full store");
`endif

endmodule

[hw/rtl/azgap_ctrl.sv]
module azgap_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  azgap_pkg::dp_status_t status,
  output azgap_pkg::dp_cmd_t    cmd
);
  import azgap_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_DECIDE     = 9'b000000010,
    S_INS_RD     = 9'b000000100,
    S_INS_CMP    = 9'b000001000,
    S_SCAN_START = 9'b000010000,
    S_SCAN_RD    = 9'b000100000,
    S_SCAN_ACC   = 9'b001000000,
    S_WRAP       = 9'b010000000,
    S_OUT        = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status.excluded && !status.full) begin
          state_next = S_INS_RD;
        end else if (status.last) begin
          state_next = S_SCAN_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_INS_RD: begin
        if (status.pos_zero) begin
          cmd.ins_place = 1'b1;
          state_next    = status.last ? S_SCAN_START : S_IDLE;
        end else begin
          cmd.ins_read = 1'b1;
          state_next   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.rd_greater) begin
          cmd.ins_shift = 1'b1;
          state_next    = S_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = status.last ? S_SCAN_START : S_IDLE;
        end
      end
      S_SCAN_START: begin
        if (status.count_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_next    = S_SCAN_ACC;
      end
      S_SCAN_ACC: begin
        cmd.scan_acc = 1'b1;
        state_next   = status.scan_last ? S_WRAP : S_SCAN_RD;
      end
      S_WRAP: begin
        cmd.scan_wrap = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/azimuthal_gap_and_distance_range.sv]
// Azimuthal gap and distance range of a set of arrivals.
// Input channel (in_valid/in_ready/in_data): one arrival word with distance,
// azimuth, excluded and last flags, angles in hundredths of a degree.
// Output channel (out_valid/out_ready/out_data): one result word per set,
// given after the word marked last: min and max distance, largest gap
// including the wrap gap, empty and overflow flags.
// A used arrival is placed by a single-port shifting insertion into the
// sorted store: each stored azimuth above it is read and moved up one
// place, then the new azimuth is written; an excluded or overflowing
// arrival is only checked and not stored.
// After the last word the gap scan reads the store once, then the result
// word is held for the receiver.
// One word is in work at a time: in_ready is low from acceptance until the
// word is finished, and while a result waits on out_ready.
// Reset clears the set and the controller; the store needs no clearing,
// as only entries below the stored count are ever read.
// A stalled receiver simply holds the result word and the block takes no
// new arrival until it is taken.
module azimuthal_gap_and_distance_range #(
  parameter int MAX_ARRIVALS = azgap_pkg::MAX_ARRIVALS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  azgap_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output azgap_pkg::out_word_t out_data
);
  import azgap_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  azgap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // store, running range and gap datapath
  azgap_dp #(
    .MAX_ARRIVALS (MAX_ARRIVALS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[tb/sv/azimuthal_gap_checker.sv]
module azimuthal_gap_checker #(
  parameter int MAX_ARRIVALS = azgap_pkg::MAX_ARRIVALS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  azgap_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  azgap_pkg::out_word_t out_data,
  output int                   fail_count,
  output int                   pending_count,
  output int                   results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import azgap_pkg::*;

  // predicted set state
  logic [15:0] az_sorted [MAX_ARRIVALS];
  int          az_count;
  logic [14:0] dist_min;
  logic [14:0] dist_max;
  logic        store_overflow;

  // result words predicted but not yet seen
  out_word_t   want_results [$];

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic clear_set();
    az_count       = 0;
    dist_min       = HALF_CIRCLE;
    dist_max       = '0;
    store_overflow = 1'b0;
  endtask

  // largest gap between neighbors, wrap gap included
  function automatic logic [15:0] widest_gap();
    int best;
    int step;
    best = int'(az_sorted[0]) + int'(FULL_CIRCLE) - int'(az_sorted[az_count - 1]);
    for (int i = 1; i < az_count; i++) begin
      step = int'(az_sorted[i]) - int'(az_sorted[i - 1]);
      if (step > best)
        best = step;
    end
    return best[15:0];
  endfunction

  // fold one accepted arrival into the set, predict the result on the last word
  task automatic take_arrival(input in_word_t w);
    logic [14:0] dist_sat;
    logic [15:0] az;
    logic        first_used;
    int          pos;
    out_word_t   res;
    dist_sat = (w.distance > HALF_CIRCLE) ? HALF_CIRCLE : w.distance;
    az       = (w.azimuth >= FULL_CIRCLE) ? w.azimuth - FULL_CIRCLE : w.azimuth;
    if (!w.excluded) begin
      first_used = (az_count == 0) && !store_overflow;
      if (first_used || dist_sat < dist_min)
        dist_min = dist_sat;
      if (first_used || dist_sat > dist_max)
        dist_max = dist_sat;
      if (az_count < MAX_ARRIVALS) begin
        // sorted insertion, larger entries move up
        pos = az_count;
        while (pos > 0 && az_sorted[pos - 1] > az) begin
          az_sorted[pos] = az_sorted[pos - 1];
          pos--;
        end
        az_sorted[pos] = az;
        az_count++;
      end else begin
        store_overflow = 1'b1;
      end
    end
    if (w.last) begin
      if (az_count == 0) begin
        res.min_distance = '0;
        res.max_distance = '0;
        res.largest_gap  = FULL_CIRCLE;
        res.empty_set    = 1'b1;
        res.overflow     = 1'b0;
      end else begin
        res.min_distance = dist_min;
        res.max_distance = dist_max;
        res.largest_gap  = widest_gap();
        res.empty_set    = 1'b0;
        res.overflow     = store_overflow;
      end
      want_results = {want_results, res};
      clear_set();
    end
  endtask

  // compare a taken result word with the oldest prediction
  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (want_results.size() == 0) begin
      report_mismatch($sformatf("result word with none expected: min %0d max %0d gap %0d",
                                got.min_distance, got.max_distance, got.largest_gap));
      return;
    end
    want = want_results.pop_front();
    results_checked++;
    compare_field("min_distance", got.min_distance, want.min_distance);
    compare_field("max_distance", got.max_distance, want.max_distance);
    compare_field("largest_gap", got.largest_gap, want.largest_gap);
    compare_field("empty_set", got.empty_set, want.empty_set);
    compare_field("overflow", got.overflow, want.overflow);
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      clear_set();
      want_results.delete();
    end else begin
      if (out_valid && out_ready)
        check_result(out_data);
      if (in_valid && in_ready)
        take_arrival(in_data);
    end
    pending_count <= want_results.size();
  end

endmodule

[tb/sv/azimuthal_gap_and_distance_range_tb.sv]
module azimuthal_gap_and_distance_range_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import azgap_pkg::*;

  localparam int STORE_DEPTH  = MAX_ARRIVALS_DEF;
  localparam int RANDOM_WORDS = 1550;
  localparam int DRAIN_CYCLES = 400;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_RUNS} ready_mode_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fail_count;
  int pending_count;
  int results_checked;

  // stimulus bookkeeping
  int words_sent    = 0;
  int used_sent     = 0;
  int sets_sent     = 0;
  int overflow_sets = 0;
  int empty_sets    = 0;
  int used_in_set   = 0;
  int burst_left    = 0;

  // receiver stall pattern
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          hold_left  = 0;

  azimuthal_gap_and_distance_range #(.MAX_ARRIVALS(STORE_DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  azimuthal_gap_checker #(.MAX_ARRIVALS(STORE_DEPTH)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .results_checked(results_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // present one arrival word, hold it until taken, then maybe pause
  task automatic send_arrival(input logic [14:0] dist_in, input logic [15:0] az,
                              input logic excl, input logic fin);
    int gap;
    in_valid <= 1'b1;
    in_data  <= {dist_in, az, excl, fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (!excl) begin
      used_sent++;
      used_in_set++;
    end
    if (fin) begin
      sets_sent++;
      if (used_in_set == 0)
        empty_sets++;
      if (used_in_set > STORE_DEPTH)
        overflow_sets++;
      used_in_set = 0;
    end
    // bursts with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // one set of random arrivals, sized by a random kind
  task automatic send_random_set();
    int          n;
    int          pick;
    int          excl_odds;
    logic        all_excl;
    logic [14:0] d;
    logic [15:0] a;
    logic        x;
    pick      = $urandom_range(0, 99);
    all_excl  = 1'b0;
    excl_odds = 10;
    if (pick < 3) begin
      // around the store size, mostly past it
      n         = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 6);
      excl_odds = 32;
    end else if (pick < 8) begin
      n        = $urandom_range(1, 4);
      all_excl = 1'b1;
    end else if (pick < 30) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(2, 14);
    end
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       d = 15'($urandom);
        1:       d = $urandom_range(0, 1) ? HALF_CIRCLE : 15'd0;
        default: d = 15'($urandom_range(0, HALF_CIRCLE));
      endcase
      case ($urandom_range(0, 9))
        0:       a = 16'($urandom);
        1:       a = $urandom_range(0, 1) ? FULL_CIRCLE - 16'd1 : 16'd0;
        2:       a = 16'd18000;
        default: a = 16'($urandom_range(0, FULL_CIRCLE - 1));
      endcase
      x = all_excl || ($urandom_range(0, excl_odds - 1) == 0);
      send_arrival(d, a, x, i == n - 1);
    end
  endtask

  // receiver stalls, mode changes at random intervals
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= $urandom_range(0, 1);
        READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default: begin
          if (hold_left == 0) begin
            out_ready <= !out_ready;
            hold_left = $urandom_range(0, 40);
          end else begin
            hold_left--;
          end
        end
      endcase
    end
  end

  // stimulus and verdict
  initial begin
    int random_from;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single arrival at zero
    send_arrival(15'd0, 16'd0, 1'b0, 1'b1);
    // one excluded word, empty set
    send_arrival(HALF_CIRCLE, FULL_CIRCLE - 16'd1, 1'b1, 1'b1);
    // field extremes, saturation, azimuth wrap, duplicate, excluded last word
    send_arrival(HALF_CIRCLE, FULL_CIRCLE - 16'd1, 1'b0, 1'b0);
    send_arrival(15'd0, 16'd0, 1'b0, 1'b0);
    send_arrival(15'h7fff, 16'hffff, 1'b0, 1'b0);
    send_arrival(15'd100, FULL_CIRCLE, 1'b0, 1'b0);
    send_arrival(15'd5, 16'd12345, 1'b1, 1'b1);
    // several excluded words
    send_arrival(15'd1, 16'd2, 1'b1, 1'b0);
    send_arrival(15'd3, 16'd4, 1'b1, 1'b1);
    // min then max move on separate words
    send_arrival(15'd500, 16'd9000, 1'b0, 1'b0);
    send_arrival(15'd400, 16'd27000, 1'b0, 1'b0);
    send_arrival(15'd600, 16'd18000, 1'b0, 1'b1);
    // all azimuths equal
    send_arrival(15'd7, 16'd100, 1'b0, 1'b0);
    send_arrival(15'd7, 16'd100, 1'b0, 1'b1);
    // out-of-range distance, gap across the wrap point
    send_arrival(HALF_CIRCLE + 15'd1, FULL_CIRCLE - 16'd1, 1'b0, 1'b0);
    send_arrival(15'd0, 16'd1, 1'b0, 1'b1);

    // random sets
    random_from = words_sent;
    while (words_sent - random_from < RANDOM_WORDS)
      send_random_set();

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d arrival words (%0d used) in %0d sets: %0d past the store, %0d empty",
             words_sent, used_sent, sets_sent, overflow_sets, empty_sets);
    $display("%0d result words compared, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("timeout with %0d result words outstanding", pending_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
hw/rtl/azgap_pkg.sv
hw/rtl/azgap_dp.sv
hw/rtl/azgap_ctrl.sv
hw/rtl/azimuthal_gap_and_distance_range.sv
tb/sv/azimuthal_gap_checker.sv
tb/sv/azimuthal_gap_and_distance_range_tb.sv
